FILE: design/bpmc_pkg.sv
// ----------------------------------------------------------------------------
// bpmc_pkg
// shared constants and types of the balance mode controller
// ----------------------------------------------------------------------------
package bpmc_pkg;

	localparam int SETTLE_SAMPLES_DEF = 100;

	localparam logic [1:0] MODE_IDLE   = 2'd0;
	localparam logic [1:0] MODE_INIT   = 2'd1;
	localparam logic [1:0] MODE_BAL    = 2'd2;
	localparam logic [1:0] MODE_FALLEN = 2'd3;

	localparam logic [1:0] ACT_COAST = 2'd0;
	localparam logic [1:0] ACT_BRAKE = 2'd1;
	localparam logic [1:0] ACT_DRIVE = 2'd2;

	localparam logic [1:0] CMD_SAMPLE = 2'd0;
	localparam logic [1:0] CMD_START  = 2'd1;
	localparam logic [1:0] CMD_STOP   = 2'd2;

	localparam logic [2:0] REG_GAIN_P  = 3'd0;
	localparam logic [2:0] REG_GAIN_I  = 3'd1;
	localparam logic [2:0] REG_GAIN_D  = 3'd2;
	localparam logic [2:0] REG_TARGET  = 3'd3;
	localparam logic [2:0] REG_WINDUP  = 3'd4;
	localparam logic [2:0] REG_DRIVE   = 3'd5;

	localparam logic signed [16:0] FALL_Q88       = 17'sd11520;
	localparam logic signed [16:0] UPRIGHT_INIT   = 17'sd7680;
	localparam logic signed [16:0] UPRIGHT_FALLEN = 17'sd2560;
	localparam logic [16:0] DEFAULT_DT_US = 17'd10000;
	localparam logic [16:0] MAX_DT_US     = 17'd100000;
	localparam logic [19:0] US_PER_S      = 20'd1000000;

	// divider request / reply between sequencer and divider
	typedef struct packed {
		logic        start;
		logic [63:0] num;    // magnitude of numerator
		logic [19:0] den;    // divisor, nonzero
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] quo;
	} div_rsp_t;

endpackage

FILE: design/bpmc_div.sv
// ----------------------------------------------------------------------------
// bpmc_div
// shared restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module bpmc_div (
	input  logic              clk,
	input  logic              arst_n,
	input  bpmc_pkg::div_req_t req,
	output bpmc_pkg::div_rsp_t rsp
);

	logic        busy_q;
	logic        done_q;
	logic [6:0]  cnt_q;
	logic [63:0] quo_q;
	logic [20:0] rem_q;
	logic [19:0] den_q;
	logic [20:0] trial;

	assign trial = {rem_q[19:0], quo_q[63]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.num;
			rem_q <= '0;
			den_q <= req.den;
		end else if (busy_q) begin
			if (trial >= {1'b0, den_q}) begin
				rem_q <= trial - {1'b0, den_q};
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

	assign rsp = {done_q, quo_q};

endmodule

FILE: design/balance_pid_mode_controller.sv
// ----------------------------------------------------------------------------
// balance_pid_mode_controller
// balancing robot mode machine with a fixed-point pid and anti-windup
// ----------------------------------------------------------------------------
// channel  | direction | handshake          | payload
// cfg      | in        | cfg_we             | cfg_index, cfg_data
// in       | in        | in_valid/in_stall  | cmd, tilt, stamp_us
// out      | out       | out_valid/out_stall| mode .. status
//
// a balancing sample within the fall limit passes through two 64-step
// passes of the shared divider (integral step, derivative), one multiply
// per pid term on the shared multiplier, clamp and output; other items
// go from decode straight to output.
// one transaction is in flight; in_stall is high from accept until the
// result leaves the output register, so output stalls delay the next accept.
// reset is asynchronous, active low, and returns every state register and
// config register to its reset value.
// ----------------------------------------------------------------------------
module balance_pid_mode_controller #(
	parameter int SETTLE_SAMPLES = bpmc_pkg::SETTLE_SAMPLES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [30:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         cmd,
	input  logic signed [15:0] tilt,
	input  logic [62:0]        stamp_us,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         mode,
	output logic [1:0]         drive_action,
	output logic [7:0]         speed,
	output logic               forward,
	output logic               balanced,
	output logic               fall_event,
	output logic               mode_changed,
	output logic               status
);

	localparam logic [8:0] SETTLE = 9'(SETTLE_SAMPLES);

	// sequencer states
	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_DECODE = 4'd1;
	localparam logic [3:0] ST_IDIV   = 4'd2;
	localparam logic [3:0] ST_IWAIT  = 4'd3;
	localparam logic [3:0] ST_DDIV   = 4'd4;
	localparam logic [3:0] ST_DWAIT  = 4'd5;
	localparam logic [3:0] ST_MP     = 4'd6;
	localparam logic [3:0] ST_MI     = 4'd7;
	localparam logic [3:0] ST_MD     = 4'd8;
	localparam logic [3:0] ST_CLAMP  = 4'd9;
	localparam logic [3:0] ST_OUT    = 4'd10;

	logic [3:0] st_q;

	// configuration
	logic signed [15:0] gain_p_q, gain_i_q, gain_d_q, target_q;
	logic [30:0] windup_q;
	logic [7:0]  dlim_q;

	// persistent state
	logic [1:0]  mode_q;
	logic [63:0] last_stamp_q;
	logic signed [31:0] integ_q;
	logic signed [16:0] prev_err_q;
	logic [7:0]  init_cnt_q, up_cnt_q;
	logic        bal_q;

	// transaction registers
	logic [1:0]  cmd_q;
	logic signed [15:0] tilt_q;
	logic [62:0] stamp_q;
	logic signed [17:0] err_q;
	logic [16:0] dt_q;
	logic signed [33:0] acc_q;
	logic signed [18:0] dd_q;
	logic signed [63:0] sum_q;
	logic signed [63:0] prod_q;

	bpmc_pkg::div_req_t dreq;
	bpmc_pkg::div_rsp_t drsp;

	bpmc_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	// shared signed multiplier: operand selected by state,
	// q8.8 terms are scaled by 256 after the multiply
	logic signed [16:0] mul_a;
	logic signed [40:0] mul_b;
	logic               mul_sh;
	logic signed [63:0] mul_y;
	always_comb begin
		mul_a  = 17'(gain_p_q);
		mul_b  = 41'(err_q);
		mul_sh = 1'b1;
		case (st_q)
			ST_MI:   begin mul_a = 17'(gain_i_q); mul_b = 41'(acc_q); mul_sh = 1'b0; end
			ST_MD:   begin mul_a = 17'(gain_d_q); mul_b = 41'(sum_q); end
			default: ;
		endcase
	end
	assign mul_y = mul_sh ? (64'(mul_a) * 64'(mul_b)) <<< 8 : 64'(mul_a) * 64'(mul_b);

	// time step
	logic [63:0] sdiff;
	logic [16:0] dt_new;
	assign sdiff = {1'b0, stamp_q} - last_stamp_q;
	always_comb begin
		dt_new = bpmc_pkg::DEFAULT_DT_US;
		if (last_stamp_q != 64'd0 && {1'b0, stamp_q} > last_stamp_q
		    && sdiff <= 64'(bpmc_pkg::MAX_DT_US))
			dt_new = sdiff[16:0];
	end

	logic signed [16:0] tilt_x, tilt_abs;
	assign tilt_x   = 17'(tilt_q);
	assign tilt_abs = tilt_x < 0 ? -tilt_x : tilt_x;

	// signed quotient from magnitude quotient
	logic neg_q;
	logic signed [63:0] squo;
	assign squo = neg_q ? -$signed(drsp.quo) : $signed(drsp.quo);

	logic signed [33:0] wl;
	logic signed [63:0] lim;
	assign wl  = 34'(windup_q);
	assign lim = 64'(dlim_q) <<< 24;

	logic [8:0] init_next, up_next;
	assign init_next = 9'(init_cnt_q) + 9'd1;
	assign up_next   = 9'(up_cnt_q) + 9'd1;

	// divider request
	logic signed [63:0] inum;
	logic signed [63:0] dnum;
	assign inum = 64'(err_q) * 64'(dt_q) * 64'sd256;
	assign dnum = 64'(19'(err_q) - 19'(prev_err_q)) * 64'sd1000000;
	always_comb begin
		dreq.start = 1'b0;
		dreq.num   = '0;
		dreq.den   = 20'd1;
		if (st_q == ST_IDIV) begin
			dreq.start = 1'b1;
			dreq.num   = inum < 0 ? 64'(-inum) : 64'(inum);
			dreq.den   = bpmc_pkg::US_PER_S;
		end else if (st_q == ST_DDIV) begin
			dreq.start = 1'b1;
			dreq.num   = dnum < 0 ? 64'(-dnum) : 64'(dnum);
			dreq.den   = 20'(dt_q);
		end
	end

	assign in_stall = (st_q != ST_IDLE);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q <= '0; gain_i_q <= '0; gain_d_q <= '0; target_q <= '0;
			windup_q <= '0; dlim_q <= 8'd100;
		end else if (cfg_we) begin
			case (cfg_index)
				bpmc_pkg::REG_GAIN_P: gain_p_q <= cfg_data[15:0];
				bpmc_pkg::REG_GAIN_I: gain_i_q <= cfg_data[15:0];
				bpmc_pkg::REG_GAIN_D: gain_d_q <= cfg_data[15:0];
				bpmc_pkg::REG_TARGET: target_q <= cfg_data[15:0];
				bpmc_pkg::REG_WINDUP: windup_q <= cfg_data;
				bpmc_pkg::REG_DRIVE:  dlim_q   <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && in_valid) begin
			cmd_q <= cmd; tilt_q <= tilt; stamp_q <= stamp_us;
		end
	end

	// mode transition helper applied in decode
	task automatic go_to(input logic [1:0] m);
		if (m != mode_q) begin
			if (mode_q == bpmc_pkg::MODE_BAL || m == bpmc_pkg::MODE_BAL) begin
				integ_q <= '0; prev_err_q <= '0;
			end
			mode_q <= m;
			if (m == bpmc_pkg::MODE_INIT) init_cnt_q <= '0;
			if (m == bpmc_pkg::MODE_FALLEN) begin
				up_cnt_q <= '0; fall_event <= 1'b1;
			end
			mode_changed <= 1'b1;
		end
	endtask

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE; out_valid <= 1'b0;
			mode_q <= bpmc_pkg::MODE_IDLE; last_stamp_q <= '0; integ_q <= '0;
			prev_err_q <= '0; init_cnt_q <= '0; up_cnt_q <= '0; bal_q <= 1'b0;
			drive_action <= '0; speed <= '0; forward <= 1'b0;
			fall_event <= 1'b0; mode_changed <= 1'b0; status <= 1'b0;
			err_q <= '0; dt_q <= '0; acc_q <= '0; dd_q <= '0; sum_q <= '0;
			prod_q <= '0; neg_q <= 1'b0;
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (in_valid) st_q <= ST_DECODE;
				end
				ST_DECODE: begin
					drive_action <= bpmc_pkg::ACT_COAST; speed <= '0; forward <= 1'b0;
					fall_event <= 1'b0; mode_changed <= 1'b0; status <= 1'b0;
					err_q <= 18'(target_q) - 18'(tilt_q);
					st_q <= ST_OUT;
					if (cmd_q == bpmc_pkg::CMD_SAMPLE) begin
						dt_q <= dt_new;
						last_stamp_q <= {1'b0, stamp_q};
						case (mode_q)
							bpmc_pkg::MODE_INIT: begin
								init_cnt_q <= init_next > 9'd255 ? 8'd255 : init_next[7:0];
								if (init_next > SETTLE)
									go_to(tilt_abs < bpmc_pkg::UPRIGHT_INIT ?
									      bpmc_pkg::MODE_BAL : bpmc_pkg::MODE_FALLEN);
							end
							bpmc_pkg::MODE_BAL: begin
								if (tilt_x > bpmc_pkg::FALL_Q88 || tilt_x < -bpmc_pkg::FALL_Q88) begin
									bal_q <= 1'b0;
									drive_action <= bpmc_pkg::ACT_BRAKE;
									go_to(bpmc_pkg::MODE_FALLEN);
								end else begin
									bal_q <= 1'b1;
									st_q <= ST_IDIV;
								end
							end
							bpmc_pkg::MODE_FALLEN: begin
								drive_action <= bpmc_pkg::ACT_BRAKE;
								if (tilt_abs < bpmc_pkg::UPRIGHT_FALLEN) begin
									up_cnt_q <= up_next > 9'd255 ? 8'd255 : up_next[7:0];
									if (up_next > SETTLE) begin
										up_cnt_q <= '0;
										go_to(bpmc_pkg::MODE_IDLE);
									end
								end else begin
									up_cnt_q <= '0;
								end
							end
							default: ;
						endcase
					end else if (cmd_q == bpmc_pkg::CMD_START) begin
						if (mode_q == bpmc_pkg::MODE_IDLE || mode_q == bpmc_pkg::MODE_FALLEN) begin
							integ_q <= '0; prev_err_q <= '0; init_cnt_q <= '0;
							go_to(bpmc_pkg::MODE_INIT);
						end else status <= 1'b1;
					end else if (cmd_q == bpmc_pkg::CMD_STOP) begin
						if (mode_q == bpmc_pkg::MODE_BAL) go_to(bpmc_pkg::MODE_IDLE);
						else status <= 1'b1;
					end else status <= 1'b1;
				end
				ST_IDIV: begin
					neg_q <= inum < 0;
					st_q <= ST_IWAIT;
				end
				ST_IWAIT: begin
					if (drsp.done) begin
						acc_q <= 34'(integ_q) + 34'(squo);
						st_q <= ST_DDIV;
					end
				end
				ST_DDIV: begin
					if (acc_q > wl) acc_q <= wl;
					else if (acc_q < -wl) acc_q <= -wl;
					neg_q <= dnum < 0;
					st_q <= ST_DWAIT;
				end
				ST_DWAIT: begin
					if (drsp.done) begin
						sum_q <= squo;
						integ_q <= 32'(acc_q);
						prev_err_q <= 17'(err_q);
						st_q <= ST_MP;
					end
				end
				ST_MP: begin
					prod_q <= mul_y;
					st_q <= ST_MI;
				end
				ST_MI: begin
					acc_q <= acc_q;
					sum_q <= sum_q;
					prod_q <= prod_q + mul_y;
					st_q <= ST_MD;
				end
				ST_MD: begin
					prod_q <= prod_q + mul_y;
					st_q <= ST_CLAMP;
				end
				ST_CLAMP: begin
					drive_action <= bpmc_pkg::ACT_DRIVE;
					if (prod_q > lim) begin
						speed <= dlim_q; forward <= dlim_q != 8'd0;
					end else if (prod_q < -lim) begin
						speed <= dlim_q; forward <= 1'b0;
					end else begin
						speed <= prod_q < 0 ? 8'((-prod_q) >>> 24) : 8'(prod_q >>> 24);
						forward <= prod_q > 0;
					end
					st_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_valid) out_valid <= 1'b1;
					else if (!out_stall) begin
						out_valid <= 1'b0;
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign mode     = mode_q;
	assign balanced = bal_q;

	a_drive_only_bal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && drive_action == bpmc_pkg::ACT_DRIVE |-> mode == bpmc_pkg::MODE_BAL)
		else $error("drive outside balancing");
	a_speed_lim: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> speed <= dlim_q || drive_action != bpmc_pkg::ACT_DRIVE)
		else $error("speed above limit");
	a_fall_mode: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && fall_event |-> mode == bpmc_pkg::MODE_FALLEN && mode_changed)
		else $error("fall event without fallen mode");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input open while result pending");

endmodule

FILE: verif/tb_balance_pid_mode_controller.sv
// ----------------------------------------------------------------------------
// tb_balance_pid_mode_controller
// self-checking testbench of the balance mode controller
// ----------------------------------------------------------------------------
// a behavioral copy of the mode machine and pid predicts one result per
// accepted transaction. results are checked in order, field by field.
// directed items come first, then full start/settle/balance/fall/recover
// cycles with random content, noise items, and several gain settings.
// both sides idle in random bursts, except in the last part of the run.
// ----------------------------------------------------------------------------
module tb_balance_pid_mode_controller;

	// cmd code 3 has no meaning; it must be rejected
	localparam logic [1:0] CMD_BAD = 2'd3;
	localparam int ITEM_TARGET = 1550;

	typedef struct packed {
		logic [1:0] mode;
		logic [1:0] action;
		logic [7:0] speed;
		logic       fwd;
		logic       bal;
		logic       fall;
		logic       chg;
		logic       stat;
	} ctrl_result_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [2:0]         cfg_index;
	logic [30:0]        cfg_data;
	logic               in_valid;
	logic               in_stall;
	logic [1:0]         cmd;
	logic signed [15:0] tilt;
	logic [62:0]        stamp_us;
	logic               out_valid;
	logic               out_stall;
	logic [1:0]         mode;
	logic [1:0]         drive_action;
	logic [7:0]         speed;
	logic               forward;
	logic               balanced;
	logic               fall_event;
	logic               mode_changed;
	logic               status;

	balance_pid_mode_controller dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.cmd(cmd), .tilt(tilt), .stamp_us(stamp_us),
		.out_valid(out_valid), .out_stall(out_stall),
		.mode(mode), .drive_action(drive_action), .speed(speed),
		.forward(forward), .balanced(balanced), .fall_event(fall_event),
		.mode_changed(mode_changed), .status(status)
	);

	// predictor copy of the config registers
	int          kp, ki, kd, setpoint;
	longint      windup;
	int          drive_lim;

	// predictor copy of the state
	logic [1:0]  st_mode;
	logic [63:0] st_last;
	int          st_integ;
	int          st_prev_err;
	int          st_init_cnt;
	int          st_up_cnt;
	bit          st_bal;
	bit          ev_fall, ev_chg;

	ctrl_result_t pending_results[$];
	int          err_count;
	int          items_sent;
	bit          jitter_on;
	logic [62:0] clock_us;
	int          out_hold;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// generous limit on the whole run
	initial begin
		#50000000;
		$display("balance_pid_mode_controller: mismatch");
		$finish;
	end

	// mode change with the clearing rules of each transition
	function automatic void switch_mode(logic [1:0] m);
		if (m == st_mode)
			return;
		if (st_mode == bpmc_pkg::MODE_BAL) begin
			st_integ = 0;
			st_prev_err = 0;
		end
		st_mode = m;
		if (m == bpmc_pkg::MODE_INIT) begin
			st_init_cnt = 0;
		end else if (m == bpmc_pkg::MODE_BAL) begin
			st_integ = 0;
			st_prev_err = 0;
		end else if (m == bpmc_pkg::MODE_FALLEN) begin
			st_up_cnt = 0;
			ev_fall = 1'b1;
		end
		ev_chg = 1'b1;
	endfunction

	// pid output in Q40.24, integral clamped, output clamped
	function automatic longint pid_drive(int angle, longint dt);
		longint e, acc, deriv, o, lim;
		e = longint'(setpoint) - angle;
		acc = longint'(st_integ) + e * 256 * dt / 1000000;
		if (acc > windup)
			acc = windup;
		else if (acc < -windup)
			acc = -windup;
		st_integ = int'(acc);
		deriv = (e - st_prev_err) * 1000000 / dt;
		st_prev_err = int'(e);
		o = longint'(kp) * e * 256 + longint'(ki) * acc + longint'(kd) * deriv * 256;
		lim = longint'(drive_lim) * 16777216;
		if (o > lim)
			o = lim;
		else if (o < -lim)
			o = -lim;
		return o;
	endfunction

	function automatic ctrl_result_t controller_step(logic [1:0] c, logic signed [15:0] a,
			logic [62:0] ts);
		ctrl_result_t r;
		int          angle;
		int          mag_a;
		longint      dt, o, mag;
		logic [63:0] stamp64;
		angle = a;
		mag_a = angle < 0 ? -angle : angle;
		stamp64 = {1'b0, ts};
		r = '0;
		r.action = bpmc_pkg::ACT_COAST;
		ev_fall = 1'b0;
		ev_chg = 1'b0;
		if (c == bpmc_pkg::CMD_SAMPLE) begin
			dt = 10000;
			if (st_last != 0 && stamp64 > st_last) begin
				if (stamp64 - st_last <= 64'd100000)
					dt = longint'(stamp64 - st_last);
			end
			st_last = stamp64;
			case (st_mode)
				bpmc_pkg::MODE_INIT: begin
					st_init_cnt = st_init_cnt + 1 > 255 ? 255 : st_init_cnt + 1;
					if (st_init_cnt > bpmc_pkg::SETTLE_SAMPLES_DEF)
						switch_mode(mag_a < 7680 ? bpmc_pkg::MODE_BAL : bpmc_pkg::MODE_FALLEN);
				end
				bpmc_pkg::MODE_BAL: begin
					if (angle > 11520 || angle < -11520) begin
						st_bal = 1'b0;
						r.action = bpmc_pkg::ACT_BRAKE;
						switch_mode(bpmc_pkg::MODE_FALLEN);
					end else begin
						st_bal = 1'b1;
						o = pid_drive(angle, dt);
						mag = o < 0 ? -o : o;
						r.action = bpmc_pkg::ACT_DRIVE;
						r.speed = 8'(mag >> 24);
						r.fwd = o > 0;
					end
				end
				bpmc_pkg::MODE_FALLEN: begin
					r.action = bpmc_pkg::ACT_BRAKE;
					if (mag_a < 2560) begin
						st_up_cnt = st_up_cnt + 1 > 255 ? 255 : st_up_cnt + 1;
						if (st_up_cnt > bpmc_pkg::SETTLE_SAMPLES_DEF) begin
							st_up_cnt = 0;
							switch_mode(bpmc_pkg::MODE_IDLE);
						end
					end else begin
						st_up_cnt = 0;
					end
				end
				default: ;
			endcase
		end else if (c == bpmc_pkg::CMD_START) begin
			if (st_mode == bpmc_pkg::MODE_IDLE || st_mode == bpmc_pkg::MODE_FALLEN) begin
				st_integ = 0;
				st_prev_err = 0;
				st_init_cnt = 0;
				switch_mode(bpmc_pkg::MODE_INIT);
			end else begin
				r.stat = 1'b1;
			end
		end else if (c == bpmc_pkg::CMD_STOP) begin
			if (st_mode == bpmc_pkg::MODE_BAL)
				switch_mode(bpmc_pkg::MODE_IDLE);
			else
				r.stat = 1'b1;
		end else begin
			r.stat = 1'b1;
		end
		r.mode = st_mode;
		r.bal = st_bal;
		r.fall = ev_fall;
		r.chg = ev_chg;
		return r;
	endfunction

	task automatic report(string what, int expv, int got);
		$display("error at %0t: %s expected %0d got %0d", $realtime, what, expv, got);
		err_count++;
	endtask

	// result checker, one transaction per accepting edge
	always @(posedge clk) begin
		ctrl_result_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				report("unexpected result, mode", -1, mode);
			end else begin
				e = pending_results.pop_front();
				if (mode !== e.mode) report("mode", e.mode, mode);
				if (drive_action !== e.action) report("drive_action", e.action, drive_action);
				if (speed !== e.speed) report("speed", e.speed, speed);
				if (forward !== e.fwd) report("forward", e.fwd, forward);
				if (balanced !== e.bal) report("balanced", e.bal, balanced);
				if (fall_event !== e.fall) report("fall_event", e.fall, fall_event);
				if (mode_changed !== e.chg) report("mode_changed", e.chg, mode_changed);
				if (status !== e.stat) report("status", e.stat, status);
			end
		end
	end

	// receiver stall in random bursts
	always @(posedge clk) begin
		if (out_hold > 0) begin
			out_hold <= out_hold - 1;
		end else if (jitter_on && $urandom_range(0, 5) == 0) begin
			out_stall <= 1'b1;
			out_hold <= $urandom_range(0, 6);
		end else begin
			out_stall <= 1'b0;
		end
	end

	// one transaction on the input channel; called at a rising edge
	task automatic send_item(logic [1:0] c, logic signed [15:0] a, logic [62:0] ts);
		if (jitter_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		tilt <= a;
		stamp_us <= ts;
		do @(posedge clk); while (in_stall);
		pending_results.push_back(controller_step(c, a, ts));
		items_sent++;
	endtask

	// wait until every result is back and the block is idle
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_regs(int p, int i, int d, int tg, logic [30:0] w, logic [7:0] lim);
		cfg_we <= 1'b1;
		cfg_index <= bpmc_pkg::REG_GAIN_P; cfg_data <= 31'(p & 16'hffff); @(posedge clk);
		cfg_index <= bpmc_pkg::REG_GAIN_I; cfg_data <= 31'(i & 16'hffff); @(posedge clk);
		cfg_index <= bpmc_pkg::REG_GAIN_D; cfg_data <= 31'(d & 16'hffff); @(posedge clk);
		cfg_index <= bpmc_pkg::REG_TARGET; cfg_data <= 31'(tg & 16'hffff); @(posedge clk);
		cfg_index <= bpmc_pkg::REG_WINDUP; cfg_data <= w; @(posedge clk);
		cfg_index <= bpmc_pkg::REG_DRIVE; cfg_data <= {23'd0, lim}; @(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		kp = 32'(signed'(16'(p)));
		ki = 32'(signed'(16'(i)));
		kd = 32'(signed'(16'(d)));
		setpoint = 32'(signed'(16'(tg)));
		windup = w;
		drive_lim = lim;
	endtask

	// next timestamp: mostly steady steps, sometimes long, backward, equal or zero
	function automatic logic [62:0] next_stamp();
		int sel;
		sel = $urandom_range(0, 39);
		if (sel == 0)
			clock_us = clock_us + $urandom_range(100001, 900000);
		else if (sel == 1)
			clock_us = clock_us - $urandom_range(1, 5000);
		else if (sel == 2)
			return 63'd0;
		else if (sel != 3)
			clock_us = clock_us + $urandom_range(1, 20000);
		return clock_us;
	endfunction

	function automatic logic signed [15:0] tilt_within(int lim);
		return 16'($urandom_range(0, 2 * lim) - lim);
	endfunction

	function automatic logic signed [15:0] tilt_beyond(int lim);
		int v;
		v = $urandom_range(lim + 1, 32767);
		if ($urandom_range(0, 1)) v = -v - ($urandom_range(0, 1));
		return 16'(v);
	endfunction

	task automatic test_directed();
		send_item(bpmc_pkg::CMD_SAMPLE, 16'sh7fff, 63'd0);
		send_item(bpmc_pkg::CMD_STOP, 16'sh0000, 63'd5);
		send_item(CMD_BAD, 16'sh8000, {63{1'b1}});
		send_item(bpmc_pkg::CMD_START, 16'sh0100, 63'd1);
		send_item(bpmc_pkg::CMD_START, 16'sh0000, 63'd2);
		send_item(bpmc_pkg::CMD_STOP, 16'sh0000, 63'd3);
		send_item(CMD_BAD, 16'sh0000, 63'd3);
		send_item(bpmc_pkg::CMD_SAMPLE, 16'sh8000, {63{1'b1}});
		send_item(bpmc_pkg::CMD_SAMPLE, 16'sh7fff, 63'd1000);
		send_item(bpmc_pkg::CMD_SAMPLE, 16'sh0000, 63'd1000);
		send_item(bpmc_pkg::CMD_SAMPLE, 16'sh0000, 63'd200000);
		send_item(bpmc_pkg::CMD_SAMPLE, 16'sh0000, 63'd300000);
		send_item(bpmc_pkg::CMD_SAMPLE, 16'sh0000, 63'd300001);
		clock_us = 63'd400000;
	endtask

	// start, settle, then balance or fall, then stop or recover
	task automatic run_cycle(bit tidy);
		int n;
		send_item(bpmc_pkg::CMD_START, tilt_within(32767), next_stamp());
		for (n = 0; n < bpmc_pkg::SETTLE_SAMPLES_DEF; n++)
			send_item(bpmc_pkg::CMD_SAMPLE,
				tilt_within($urandom_range(0, 3) == 0 ? 32767 : 7000), next_stamp());
		if (!tidy && $urandom_range(0, 4) == 0)
			send_item(bpmc_pkg::CMD_SAMPLE,
				$urandom_range(0, 1) ? tilt_beyond(7679) : 16'sd7680, next_stamp());
		else
			send_item(bpmc_pkg::CMD_SAMPLE, tilt_within(7679), next_stamp());
		if (st_mode == bpmc_pkg::MODE_BAL) begin
			repeat ($urandom_range(5, 40)) begin
				if (!tidy && $urandom_range(0, 40) == 0)
					send_item(bpmc_pkg::CMD_START, tilt_within(32767), next_stamp());
				send_item(bpmc_pkg::CMD_SAMPLE,
					tilt_within($urandom_range(0, 3) == 0 ? 11520 : 1500), next_stamp());
			end
			if ($urandom_range(0, 1))
				send_item(bpmc_pkg::CMD_STOP, tilt_within(32767), next_stamp());
			else
				send_item(bpmc_pkg::CMD_SAMPLE,
					$urandom_range(0, 3) == 0 ? 16'sd11521 : tilt_beyond(11520), next_stamp());
		end
		if (st_mode == bpmc_pkg::MODE_FALLEN) begin
			if (!tidy && $urandom_range(0, 1)) begin
				repeat ($urandom_range(10, 60))
					send_item(bpmc_pkg::CMD_SAMPLE, tilt_within(2559), next_stamp());
				send_item(bpmc_pkg::CMD_SAMPLE,
					$urandom_range(0, 1) ? 16'sd2560 : tilt_beyond(2560), next_stamp());
			end
			if ($urandom_range(0, 3) == 0 && !tidy) begin
				send_item(bpmc_pkg::CMD_STOP, 16'sd0, next_stamp());
			end else begin
				while (st_mode == bpmc_pkg::MODE_FALLEN)
					send_item(bpmc_pkg::CMD_SAMPLE, tilt_within(2559), next_stamp());
			end
		end
	endtask

	task automatic test_noise(int count);
		logic [1:0] c;
		repeat (count) begin
			c = 2'($urandom);
			send_item(c, 16'($urandom), {31'($urandom), 32'($urandom)});
		end
	endtask

	task automatic test_zero_gains();
		write_regs(0, 0, 0, 0, 31'd0, 8'd100);
		run_cycle(1'b0);
		drain();
	endtask

	task automatic test_extreme_gains();
		write_regs(32767, -32768, 32767, 32767, 31'h7fffffff, 8'd255);
		run_cycle(1'b0);
		drain();
		write_regs(-32768, 32767, -32768, -32768, 31'd0, 8'd0);
		run_cycle(1'b0);
		drain();
	endtask

	task automatic test_random_cycles();
		while (items_sent < ITEM_TARGET - 250) begin
			write_regs($urandom_range(0, 2047) - 1024, $urandom_range(0, 2047) - 1024,
				$urandom_range(0, 255) - 128, $urandom_range(0, 2560) - 1280,
				$urandom_range(0, 3) == 0 ? 31'($urandom) : 31'($urandom_range(0, 1 << 22)),
				8'($urandom));
			run_cycle(1'b0);
			if ($urandom_range(0, 1))
				test_noise($urandom_range(5, 25));
			drain();
		end
	endtask

	// last part: no idling on either side
	task automatic test_steady();
		jitter_on = 1'b0;
		write_regs(300, 40, 20, 0, 31'd200000, 8'd180);
		run_cycle(1'b1);
		drain();
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = bpmc_pkg::REG_GAIN_P;
		cfg_data = '0;
		in_valid = 1'b0;
		cmd = bpmc_pkg::CMD_SAMPLE;
		tilt = '0;
		stamp_us = '0;
		out_stall = 1'b0;
		out_hold = 0;
		err_count = 0;
		items_sent = 0;
		jitter_on = 1'b1;
		clock_us = 63'd1;
		kp = 0; ki = 0; kd = 0; setpoint = 0;
		windup = 0;
		drive_lim = 100;
		st_mode = bpmc_pkg::MODE_IDLE;
		st_last = '0;
		st_integ = 0;
		st_prev_err = 0;
		st_init_cnt = 0;
		st_up_cnt = 0;
		st_bal = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		drain();
		test_zero_gains();
		test_extreme_gains();
		test_random_cycles();
		test_steady();
		if (err_count == 0)
			$display("balance_pid_mode_controller: match");
		else
			$display("balance_pid_mode_controller: mismatch");
		$finish;
	end

endmodule

FILE: balance_pid_mode_controller.f
design/bpmc_pkg.sv
design/bpmc_div.sv
design/balance_pid_mode_controller.sv
verif/tb_balance_pid_mode_controller.sv
